>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg
// Types and constants of the load cell converter serial reader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcr_pkg;

	localparam int WEIGHT_W   = 25;
	localparam int OFFSET_W   = 24;
	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 16;
	localparam int HALF_W     = 8;
	localparam int SETTLE_W   = 16;
	localparam int FINAL_W    = 8;
	localparam int TICK_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [OFFSET_W-1:0] ZERO_OFFSET_RST = 24'd198650;
	localparam logic [GAIN_W-1:0]   GAIN_RST        = 16'd2979;
	localparam logic [HALF_W-1:0]   HALF_RST        = 8'd4;
	localparam logic [SETTLE_W-1:0] SETTLE_RST      = 16'd2000;
	localparam logic [FINAL_W-1:0]  FINAL_RST       = 8'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ZERO_OFFSET = 3'd0,
		CFG_GAIN_Q16    = 3'd1,
		CFG_HALF_PERIOD = 3'd2,
		CFG_SETTLE      = 3'd3,
		CFG_FINAL_HIGH  = 3'd4
	} cfg_idx_t;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_SETTLE = 6'b000010,
		PH_WAIT   = 6'b000100,
		PH_HIGH   = 6'b001000,
		PH_LOW    = 6'b010000,
		PH_EXTRA  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic                clamped;
	} lcr_result_t;

endpackage

>>> rtl/lcr_scale.sv
// ----------------------------------------------------------------------------
// lcr_scale
// Negate the signed converter code, add the zero offset, scale by the Q16
// gain, then clamp negatives to zero and saturate at the weight range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcr_scale #(
	parameter int DATA_BITS = 24
) (
	input  logic [DATA_BITS-1:0]         code,
	input  logic [lcr_pkg::OFFSET_W-1:0] zero_offset,
	input  logic [lcr_pkg::GAIN_W-1:0]   gain_q16,
	output lcr_pkg::lcr_result_t         result
);

	localparam int SUM_W  = ((DATA_BITS > lcr_pkg::OFFSET_W) ? DATA_BITS : lcr_pkg::OFFSET_W) + 2;
	localparam int PROD_W = SUM_W + lcr_pkg::GAIN_W + 1;
	localparam int SHR_W  = PROD_W - lcr_pkg::GAIN_FRAC;

	logic signed [SUM_W-1:0]  code_ext;
	logic signed [SUM_W-1:0]  offs_ext;
	logic signed [SUM_W-1:0]  sum;
	logic signed [lcr_pkg::GAIN_W:0] gain_ext;
	logic signed [PROD_W-1:0] prod;
	logic [SHR_W-1:0]         shr;
	logic                     ovf;

	assign code_ext = SUM_W'($signed(code));
	assign offs_ext = $signed(SUM_W'(zero_offset));
	assign sum      = offs_ext - code_ext;
	assign gain_ext = $signed({1'b0, gain_q16});
	assign prod     = PROD_W'(sum) * PROD_W'(gain_ext);
	assign shr      = prod[PROD_W-1:lcr_pkg::GAIN_FRAC];
	assign ovf      = |shr[SHR_W-1:lcr_pkg::WEIGHT_W];

	always_comb begin
		if (prod[PROD_W-1]) begin
			result.weight  = '0;
			result.clamped = 1'b1;
		end else begin
			result.weight  = ovf ? '1 : shr[lcr_pkg::WEIGHT_W-1:0];
			result.clamped = 1'b0;
		end
	end

endmodule

>>> rtl/load_cell_adc_serial_reader.sv
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader
// Bit-bang reader for a load cell converter: settle, wait for data ready,
// clock in a signed code MSB first, add the gain-select pulse, then scale.
// ----------------------------------------------------------------------------
//  channel | signals                                   | moves
//  in      | in_valid/in_ready, start_req, dout_level  | one time tick
//  out     | out_valid/out_ready, sck_level, busy_res, | pin and status state
//          | result_valid, weight, clamped             |   after each tick
//  cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data  | register write
//
//  One tick per clock cycle sustained while out_ready does not stall the result; a request
//  passes the input register and then the result register on its way to the result.
//  Offset, negate, multiply and saturate are combinational, ahead of the result register.
//  While out_ready is low the result holds and the input register takes one more tick.
//  Asynchronous reset loads the register defaults and returns to idle at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module load_cell_adc_serial_reader #(
	parameter int DATA_BITS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           start_req,
	input  logic                           dout_level,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           sck_level,
	output logic                           busy_res,
	output logic                           result_valid,
	output logic [lcr_pkg::WEIGHT_W-1:0]   weight,
	output logic                           clamped,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lcr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lcr_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int BCNT_W = $clog2(DATA_BITS + 1);

	logic [lcr_pkg::OFFSET_W-1:0] zero_offset_q;
	logic [lcr_pkg::GAIN_W-1:0]   gain_q;
	logic [lcr_pkg::HALF_W-1:0]   half_q;
	logic [lcr_pkg::SETTLE_W-1:0] settle_q;
	logic [lcr_pkg::FINAL_W-1:0]  final_q;

	logic valid_s1, start_s1, dout_s1, adv;

	lcr_pkg::phase_t              phase_q, phase_d;
	logic [lcr_pkg::TICK_W-1:0]   tick_q, tick_d, tick_dec, half_load, final_load;
	logic [BCNT_W-1:0]            bit_q, bit_d;
	logic [DATA_BITS-1:0]         shift_q, shift_d;
	logic                         sck_d, busy_d, done_d;
	lcr_pkg::lcr_result_t         calc, res_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q <= lcr_pkg::ZERO_OFFSET_RST;
			gain_q        <= lcr_pkg::GAIN_RST;
			half_q        <= lcr_pkg::HALF_RST;
			settle_q      <= lcr_pkg::SETTLE_RST;
			final_q       <= lcr_pkg::FINAL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lcr_pkg::CFG_ZERO_OFFSET: zero_offset_q <= cfg_data[lcr_pkg::OFFSET_W-1:0];
				lcr_pkg::CFG_GAIN_Q16:    gain_q        <= cfg_data[lcr_pkg::GAIN_W-1:0];
				lcr_pkg::CFG_HALF_PERIOD: half_q        <= cfg_data[lcr_pkg::HALF_W-1:0];
				lcr_pkg::CFG_SETTLE:      settle_q      <= cfg_data[lcr_pkg::SETTLE_W-1:0];
				lcr_pkg::CFG_FINAL_HIGH:  final_q       <= cfg_data[lcr_pkg::FINAL_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	assign adv      = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			start_s1 <= start_req;
			dout_s1  <= dout_level;
		end
	end

	lcr_scale #(
		.DATA_BITS(DATA_BITS)
	) u_scale (
		.code       (shift_q),
		.zero_offset(zero_offset_q),
		.gain_q16   (gain_q),
		.result     (calc)
	);

	assign tick_dec   = tick_q - 1'b1;
	assign half_load  = (half_q == '0) ? lcr_pkg::TICK_W'(1) : lcr_pkg::TICK_W'(half_q);
	assign final_load = (final_q == '0) ? lcr_pkg::TICK_W'(1) : lcr_pkg::TICK_W'(final_q);

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		sck_d   = sck_level;
		done_d  = 1'b0;
		res_d.weight  = weight;
		res_d.clamped = clamped;
		unique case (phase_q)
			lcr_pkg::PH_IDLE: begin
				sck_d = 1'b0;
				if (start_s1) begin
					if (settle_q == '0) begin
						phase_d = lcr_pkg::PH_WAIT;
						tick_d  = '0;
					end else begin
						phase_d = lcr_pkg::PH_SETTLE;
						tick_d  = settle_q;
					end
				end
			end
			lcr_pkg::PH_SETTLE: begin
				sck_d  = 1'b0;
				tick_d = tick_dec;
				if (tick_dec == '0) begin
					phase_d = lcr_pkg::PH_WAIT;
				end
			end
			lcr_pkg::PH_WAIT: begin
				sck_d = 1'b0;
				if (!dout_s1) begin
					sck_d   = 1'b1;
					phase_d = lcr_pkg::PH_HIGH;
					tick_d  = half_load;
					bit_d   = '0;
					shift_d = '0;
				end
			end
			lcr_pkg::PH_HIGH: begin
				tick_d = tick_dec;
				if (tick_dec == '0) begin
					sck_d   = 1'b0;
					phase_d = lcr_pkg::PH_LOW;
					tick_d  = half_load;
				end
			end
			lcr_pkg::PH_LOW: begin
				tick_d = tick_dec;
				if (tick_dec == '0) begin
					shift_d = {shift_q[DATA_BITS-2:0], dout_s1};
					bit_d   = bit_q + 1'b1;
					sck_d   = 1'b1;
					if (bit_q >= BCNT_W'(DATA_BITS - 1)) begin
						phase_d = lcr_pkg::PH_EXTRA;
						tick_d  = final_load;
					end else begin
						phase_d = lcr_pkg::PH_HIGH;
						tick_d  = half_load;
					end
				end
			end
			lcr_pkg::PH_EXTRA: begin
				tick_d = tick_dec;
				if (tick_dec == '0) begin
					sck_d   = 1'b0;
					phase_d = lcr_pkg::PH_IDLE;
					bit_d   = '0;
					res_d   = calc;
					done_d  = 1'b1;
				end
			end
			default: begin
				phase_d = lcr_pkg::PH_IDLE;
				sck_d   = 1'b0;
			end
		endcase
		busy_d = (phase_d != lcr_pkg::PH_IDLE);
	end

	// sequence state and result register, both advance per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= lcr_pkg::PH_IDLE;
			tick_q       <= '0;
			bit_q        <= '0;
			shift_q      <= '0;
			out_valid    <= 1'b0;
			sck_level    <= 1'b0;
			busy_res     <= 1'b0;
			result_valid <= 1'b0;
			weight       <= '0;
			clamped      <= 1'b0;
		end else begin
			if (adv) begin
				phase_q      <= phase_d;
				tick_q       <= tick_d;
				bit_q        <= bit_d;
				shift_q      <= shift_d;
				out_valid    <= 1'b1;
				sck_level    <= sck_d;
				busy_res     <= busy_d;
				result_valid <= done_d;
				weight       <= res_d.weight;
				clamped      <= res_d.clamped;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/lcr_checker.sv
// ----------------------------------------------------------------------------
// lcr_checker
// Port-level checks on the reader's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lcr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         sck_level,
	input logic                         busy_res,
	input logic                         result_valid,
	input logic [lcr_pkg::WEIGHT_W-1:0] weight,
	input logic                         clamped
);

	logic [lcr_pkg::WEIGHT_W+1:0] held;

	assign held = {weight, clamped, sck_level};

	`ASSERT_NEXT(a_stall_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(held))
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, out_valid && result_valid, !busy_res && !sck_level)
	`ASSERT_IMPLIES(a_idle_sck_low, clk, arst_n, out_valid && !busy_res, !sck_level)
	`ASSERT_IMPLIES(a_clamp_zero, clk, arst_n, out_valid && clamped, weight == '0)

endmodule

bind load_cell_adc_serial_reader lcr_checker u_lcr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.sck_level   (sck_level),
	.busy_res    (busy_res),
	.result_valid(result_valid),
	.weight      (weight),
	.clamped     (clamped)
);
